// ----- rtl/core/qns_pkg.sv -----
// Shared types and constants of the quaternion norm sort and search block.
// Depends on nothing; qns_if, the top level and qns_norm refer to it.
`default_nettype none

package qns_pkg;

	localparam int COMP_W     = 16;
	localparam int NCOMP      = 4;
	localparam int NORM_W     = 33;
	localparam int OUT_NORM_W = 32;
	localparam int FUNC_W     = 3;
	localparam int STAT_W     = 2;
	localparam int CNT_OUT_W  = 7;
	localparam int IDX_OUT_W  = 6;
	localparam int TAG_IO_W   = 8;
	localparam int READ_IDX_W = 6;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD   = 3'd0,
		FN_SORT   = 3'd1,
		FN_SEARCH = 3'd2,
		FN_READ   = 3'd3,
		FN_CLEAR  = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef logic signed [COMP_W-1:0] comp_t;
	// Element 0 is the scalar part, then i, j and k.
	typedef comp_t [NCOMP-1:0] quat_t;

endpackage

`default_nettype wire

// ----- rtl/core/qns_if.sv -----
// Request and response channel interfaces of the quaternion table block.
// Depends on qns_pkg for the field widths.
`default_nettype none

interface qns_req_if;
	logic valid;
	logic ready;
	logic [qns_pkg::FUNC_W-1:0] func;
	logic signed [qns_pkg::COMP_W-1:0] comp_real;
	logic signed [qns_pkg::COMP_W-1:0] comp_i;
	logic signed [qns_pkg::COMP_W-1:0] comp_j;
	logic signed [qns_pkg::COMP_W-1:0] comp_k;
	logic [qns_pkg::TAG_IO_W-1:0] tag_in;
	logic [qns_pkg::READ_IDX_W-1:0] read_index;

	modport source (output valid, func, comp_real, comp_i, comp_j, comp_k, tag_in, read_index,
		input ready);
	modport sink (input valid, func, comp_real, comp_i, comp_j, comp_k, tag_in, read_index,
		output ready);
endinterface

interface qns_rsp_if;
	logic valid;
	logic ready;
	logic [qns_pkg::STAT_W-1:0] status;
	logic [qns_pkg::CNT_OUT_W-1:0] entry_count;
	logic [qns_pkg::IDX_OUT_W-1:0] found_index;
	logic signed [qns_pkg::COMP_W-1:0] out_real;
	logic signed [qns_pkg::COMP_W-1:0] out_i;
	logic signed [qns_pkg::COMP_W-1:0] out_j;
	logic signed [qns_pkg::COMP_W-1:0] out_k;
	logic [qns_pkg::OUT_NORM_W-1:0] out_norm;
	logic [qns_pkg::TAG_IO_W-1:0] tag_out;

	modport source (output valid, status, entry_count, found_index, out_real, out_i, out_j,
		out_k, out_norm, tag_out, input ready);
	modport sink (input valid, status, entry_count, found_index, out_real, out_i, out_j,
		out_k, out_norm, tag_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/quaternion_norm_sort_search.sv -----
// Top level: quaternion table kept in RAM, sorted by squared norm with an
// iterative quicksort over a range stack RAM, searched by binary search.
// Depends on qns_pkg, qns_if, qns_ram and qns_norm.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------------
//  req     | in  | valid/ready | func, comp_real/i/j/k, tag_in, read_index
//  rsp     | out | valid/ready | status, entry_count, found_index, out_*, tag_out
//
// One item is worked on at a time. Load and search first wait on the shared squarer;
// search then probes the entry RAM once per halving step, read reads one entry. Sort
// pops a range, reads its pivot, scans from both ends, swaps, then pushes the parts,
// about n log n up to n squared steps.
// Reset clears the state, the count, the stack pointer and the output valid only; no clearing pass is needed.
// A new item is taken while a finished result still waits in the output register.
`default_nettype none

module quaternion_norm_sort_search #(
	parameter int DEPTH    = 64,
	parameter int TAG_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	qns_req_if.sink   req,
	qns_rsp_if.source rsp
);

	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SW    = IW + 2;
	localparam int WW    = (CW > qns_pkg::READ_IDX_W) ? CW : qns_pkg::READ_IDX_W;
	localparam int QW    = qns_pkg::NCOMP * qns_pkg::COMP_W;
	localparam int NLO   = QW;
	localparam int NHI   = QW + qns_pkg::NORM_W - 1;
	localparam int TLO   = NHI + 1;
	localparam int EW    = QW + qns_pkg::NORM_W + TAG_BITS;
	localparam logic signed [SW-1:0] S_ONE = SW'(1);

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_NORM  = 17'b00000000000000010,
		S_SRD   = 17'b00000000000000100,
		S_SCK   = 17'b00000000000001000,
		S_ECK   = 17'b00000000000010000,
		S_RCK   = 17'b00000000000100000,
		S_POP   = 17'b00000000001000000,
		S_POPD  = 17'b00000000010000000,
		S_PIV   = 17'b00000000100000000,
		S_ACK   = 17'b00000001000000000,
		S_BCK   = 17'b00000010000000000,
		S_SWA   = 17'b00000100000000000,
		S_SWB   = 17'b00001000000000000,
		S_PUSH1 = 17'b00010000000000000,
		S_PUSH2 = 17'b00100000000000000,
		S_DONE  = 17'b01000000000000000,
		S_SPARE = 17'b10000000000000000
	} state_t;

	state_t                       state_q;
	qns_pkg::func_t               func_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                sp_q;
	qns_pkg::quat_t               quat_q;
	logic [TAG_BITS-1:0]          tag_q;
	logic [qns_pkg::NORM_W-1:0]   key_q;
	logic [qns_pkg::NORM_W-1:0]   piv_q;
	logic signed [SW-1:0]         a_q;
	logic signed [SW-1:0]         b_q;
	logic [IW-1:0]                lo_q;
	logic [IW-1:0]                hi_q;
	logic [IW-1:0]                m_q;
	logic [EW-1:0]                ea_q;
	logic [EW-1:0]                eb_q;

	qns_pkg::status_t             res_status_q;
	logic [IW-1:0]                res_idx_q;
	qns_pkg::quat_t               res_quat_q;
	logic [qns_pkg::NORM_W-1:0]   res_norm_q;
	logic [TAG_BITS-1:0]          res_tag_q;

	logic                         out_valid_q;
	qns_pkg::status_t             out_status_q;
	logic [qns_pkg::CNT_OUT_W-1:0] out_count_q;
	logic [qns_pkg::IDX_OUT_W-1:0] out_idx_q;
	qns_pkg::quat_t               out_quat_q;
	logic [qns_pkg::OUT_NORM_W-1:0] out_norm_q;
	logic [qns_pkg::TAG_IO_W-1:0] out_tag_q;

	logic                         e_we;
	logic [IW-1:0]                e_waddr;
	logic [EW-1:0]                e_wdata;
	logic [IW-1:0]                e_raddr;
	logic [EW-1:0]                e_rdata;
	logic                         s_we;
	logic [IW-1:0]                s_waddr;
	logic [2*IW-1:0]              s_wdata;
	logic [IW-1:0]                s_raddr;
	logic [2*IW-1:0]              s_rdata;

	logic                         n_start;
	qns_pkg::quat_t               n_quat;
	logic                         n_done;
	logic [qns_pkg::NORM_W-1:0]   n_norm;

	logic                         acc_in;
	qns_pkg::func_t               req_func;
	logic [WW-1:0]                ridx_w;
	logic                         ridx_bad;
	logic [CW-1:0]                cnt_m1;
	logic [CW-1:0]                sp_m1;
	logic signed [SW-1:0]         cnt_s;
	logic signed [SW-1:0]         lo_s;
	logic signed [SW-1:0]         hi_s;
	logic signed [SW-1:0]         s_mid;
	logic signed [SW-1:0]         a_p1;
	logic signed [SW-1:0]         b_m1;
	logic [qns_pkg::NORM_W-1:0]   rd_norm;
	logic [IW-1:0]                pop_lo;
	logic [IW-1:0]                pop_hi;
	logic [IW-1:0]                piv_idx;
	logic                         ack_go;
	logic                         bck_go;
	logic                         left_ok;
	logic                         right_ok;
	logic                         left_first;
	logic [2*IW-1:0]              right_rng;
	logic                         first_ok;
	logic                         second_ok;
	logic [2*IW-1:0]              first_rng;
	logic [2*IW-1:0]              second_rng;
	logic                         out_free;
	logic                         out_load;

	function automatic logic [IW-1:0] a_m1_idx(input logic signed [SW-1:0] a);
		logic signed [SW-1:0] t;
		t = a - S_ONE;
		return t[IW-1:0];
	endfunction

	assign req.ready = (state_q == S_IDLE);
	assign acc_in    = req.valid && req.ready;
	assign req_func  = qns_pkg::func_t'(req.func);
	assign ridx_w    = WW'(req.read_index);
	assign ridx_bad  = ridx_w >= WW'(count_q);
	assign cnt_m1    = count_q - 1'b1;
	assign sp_m1     = sp_q - 1'b1;
	assign cnt_s     = SW'(count_q);
	assign lo_s      = SW'(lo_q);
	assign hi_s      = SW'(hi_q);
	assign s_mid     = a_q + ((b_q - a_q) >>> 1);
	assign a_p1      = a_q + S_ONE;
	assign b_m1      = b_q - S_ONE;
	assign rd_norm   = e_rdata[NHI:NLO];
	assign pop_lo    = s_rdata[IW-1:0];
	assign pop_hi    = s_rdata[2*IW-1:IW];
	assign piv_idx   = pop_lo + ((pop_hi - pop_lo) >> 1);
	assign ack_go    = (a_q < hi_s) && (rd_norm < piv_q);
	assign bck_go    = (b_q > lo_s) && (rd_norm > piv_q);
	assign n_quat    = {req.comp_k, req.comp_j, req.comp_i, req.comp_real};
	assign n_start   = acc_in && ((req_func == qns_pkg::FN_LOAD && count_q < CW'(DEPTH))
		|| req_func == qns_pkg::FN_SEARCH);
	assign out_free  = !out_valid_q || rsp.ready;
	assign out_load  = (state_q == S_DONE) && out_free;

	// Split point is a_q: the left part is lo..a-1 and the right part a..hi.
	// Ranges of one entry or none are never pushed.
	assign left_ok    = a_q > (lo_s + S_ONE);
	assign right_ok   = hi_s > a_q;
	assign left_first = (a_q - lo_s) < (hi_s - a_q);
	assign right_rng  = {hi_q, a_q[IW-1:0]};
	assign first_ok   = left_first ? left_ok : right_ok;
	assign second_ok  = left_first ? right_ok : left_ok;
	assign first_rng  = left_first ? {a_m1_idx(a_q), lo_q} : right_rng;
	assign second_rng = left_first ? right_rng : {a_m1_idx(a_q), lo_q};

	qns_ram #(.W(EW), .D(DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	qns_ram #(.W(2*IW), .D(DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	qns_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (n_start),
		.quat   (n_quat),
		.done   (n_done),
		.norm   (n_norm)
	);

	always_comb begin
		e_we    = 1'b0;
		e_waddr = count_q[IW-1:0];
		e_wdata = {tag_q, n_norm, quat_q};
		e_raddr = ridx_w[IW-1:0];
		s_we    = 1'b0;
		s_waddr = sp_q[IW-1:0];
		s_wdata = first_rng;
		s_raddr = sp_m1[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (acc_in && req_func == qns_pkg::FN_SORT && count_q >= CW'(2)) begin
					s_we    = 1'b1;
					s_waddr = '0;
					s_wdata = {cnt_m1[IW-1:0], {IW{1'b0}}};
				end
			end
			S_NORM: begin
				e_we = n_done && (func_q == qns_pkg::FN_LOAD);
			end
			S_SRD: begin
				e_raddr = (a_q <= b_q) ? s_mid[IW-1:0] : a_q[IW-1:0];
			end
			S_POPD: begin
				e_raddr = piv_idx;
			end
			S_PIV: begin
				e_raddr = lo_q;
			end
			S_ACK: begin
				e_raddr = ack_go ? a_p1[IW-1:0] : b_q[IW-1:0];
			end
			S_BCK: begin
				e_raddr = b_m1[IW-1:0];
			end
			S_SWA: begin
				e_we    = 1'b1;
				e_waddr = a_q[IW-1:0];
				e_wdata = eb_q;
			end
			S_SWB: begin
				e_we    = 1'b1;
				e_waddr = b_q[IW-1:0];
				e_wdata = ea_q;
				e_raddr = a_p1[IW-1:0];
			end
			S_PUSH1: begin
				s_we    = first_ok && (sp_q < CW'(DEPTH));
				s_wdata = first_rng;
			end
			S_PUSH2: begin
				s_we    = second_ok && (sp_q < CW'(DEPTH));
				s_wdata = second_rng;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						func_q     <= req_func;
						quat_q     <= n_quat;
						tag_q      <= TAG_BITS'(req.tag_in);
						res_idx_q  <= (req_func == qns_pkg::FN_READ && !ridx_bad)
							? ridx_w[IW-1:0] : '0;
						res_quat_q <= '0;
						res_norm_q <= '0;
						res_tag_q  <= '0;
						case (req_func)
							qns_pkg::FN_LOAD: begin
								if (count_q >= CW'(DEPTH)) begin
									res_status_q <= qns_pkg::ST_FULL;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= qns_pkg::ST_OK;
									state_q      <= S_NORM;
								end
							end
							qns_pkg::FN_SORT: begin
								res_status_q <= qns_pkg::ST_OK;
								if (count_q >= CW'(2)) begin
									sp_q    <= CW'(1);
									state_q <= S_POP;
								end else begin
									sp_q    <= '0;
									state_q <= S_DONE;
								end
							end
							qns_pkg::FN_SEARCH: begin
								res_status_q <= qns_pkg::ST_OK;
								state_q      <= S_NORM;
							end
							qns_pkg::FN_READ: begin
								if (ridx_bad) begin
									res_status_q <= qns_pkg::ST_RANGE;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= qns_pkg::ST_OK;
									state_q      <= S_RCK;
								end
							end
							qns_pkg::FN_CLEAR: begin
								res_status_q <= qns_pkg::ST_OK;
								count_q      <= '0;
								sp_q         <= '0;
								state_q      <= S_DONE;
							end
							default: begin
								res_status_q <= qns_pkg::ST_OK;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_NORM: begin
					if (n_done) begin
						if (func_q == qns_pkg::FN_LOAD) begin
							res_idx_q  <= count_q[IW-1:0];
							res_quat_q <= quat_q;
							res_norm_q <= n_norm;
							res_tag_q  <= tag_q;
							count_q    <= count_q + 1'b1;
							state_q    <= S_DONE;
						end else begin
							key_q   <= n_norm;
							a_q     <= '0;
							b_q     <= cnt_s - S_ONE;
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					if (a_q <= b_q) begin
						m_q     <= s_mid[IW-1:0];
						state_q <= S_SCK;
					end else if (a_q < cnt_s) begin
						m_q     <= a_q[IW-1:0];
						state_q <= S_ECK;
					end else begin
						res_status_q <= qns_pkg::ST_MISS;
						state_q      <= S_DONE;
					end
				end
				S_SCK: begin
					if (rd_norm == key_q) begin
						res_idx_q  <= m_q;
						res_quat_q <= e_rdata[QW-1:0];
						res_norm_q <= rd_norm;
						res_tag_q  <= e_rdata[EW-1:TLO];
						state_q    <= S_DONE;
					end else begin
						if (key_q < rd_norm) begin
							b_q <= SW'(m_q) - S_ONE;
						end else begin
							a_q <= SW'(m_q) + S_ONE;
						end
						state_q <= S_SRD;
					end
				end
				S_ECK: begin
					if (rd_norm == key_q) begin
						res_idx_q  <= m_q;
						res_quat_q <= e_rdata[QW-1:0];
						res_norm_q <= rd_norm;
						res_tag_q  <= e_rdata[EW-1:TLO];
					end else begin
						res_status_q <= qns_pkg::ST_MISS;
					end
					state_q <= S_DONE;
				end
				S_RCK: begin
					res_quat_q <= e_rdata[QW-1:0];
					res_norm_q <= rd_norm;
					res_tag_q  <= e_rdata[EW-1:TLO];
					state_q    <= S_DONE;
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_DONE;
					end else begin
						sp_q    <= sp_m1;
						state_q <= S_POPD;
					end
				end
				S_POPD: begin
					lo_q    <= pop_lo;
					hi_q    <= pop_hi;
					state_q <= S_PIV;
				end
				S_PIV: begin
					piv_q   <= rd_norm;
					a_q     <= lo_s;
					b_q     <= hi_s;
					state_q <= S_ACK;
				end
				S_ACK: begin
					if (ack_go) begin
						a_q <= a_p1;
					end else begin
						ea_q    <= e_rdata;
						state_q <= S_BCK;
					end
				end
				S_BCK: begin
					if (bck_go) begin
						b_q <= b_m1;
					end else begin
						eb_q <= e_rdata;
						if (a_q <= b_q) begin
							state_q <= S_SWA;
						end else begin
							state_q <= S_PUSH1;
						end
					end
				end
				S_SWA: begin
					state_q <= S_SWB;
				end
				S_SWB: begin
					a_q <= a_p1;
					b_q <= b_m1;
					if (a_p1 <= b_m1) begin
						state_q <= S_ACK;
					end else begin
						state_q <= S_PUSH1;
					end
				end
				S_PUSH1: begin
					if (first_ok && sp_q < CW'(DEPTH)) begin
						sp_q <= sp_q + 1'b1;
					end
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (second_ok && sp_q < CW'(DEPTH)) begin
						sp_q <= sp_q + 1'b1;
					end
					state_q <= S_POP;
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_count_q  <= qns_pkg::CNT_OUT_W'(count_q);
						out_idx_q    <= qns_pkg::IDX_OUT_W'(res_idx_q);
						out_quat_q   <= res_quat_q;
						out_norm_q   <= res_norm_q[qns_pkg::NORM_W-1] ? '1
							: res_norm_q[qns_pkg::OUT_NORM_W-1:0];
						out_tag_q    <= qns_pkg::TAG_IO_W'(res_tag_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.found_index = out_idx_q;
	assign rsp.out_real    = out_quat_q[0];
	assign rsp.out_i       = out_quat_q[1];
	assign rsp.out_j       = out_quat_q[2];
	assign rsp.out_k       = out_quat_q[3];
	assign rsp.out_norm    = out_norm_q;
	assign rsp.tag_out     = out_tag_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds table depth");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(DEPTH))
		else $error("range stack pointer exceeds stack depth");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NORM && e_we) |-> count_q < CW'(DEPTH))
		else $error("load written into a full table");

	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWB |-> a_q <= b_q)
		else $error("partition swap with crossed indexes");

	a_pop_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POPD |-> (pop_hi > pop_lo && SW'(pop_hi) < cnt_s))
		else $error("popped range is empty or beyond the count");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/qns_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module qns_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/qns_norm.sv -----
// Squared norm unit: one squarer shared over the four components, one per cycle.
// Depends on qns_pkg.
`default_nettype none

module qns_norm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire qns_pkg::quat_t                quat,
	output logic                               done,
	output logic [qns_pkg::NORM_W-1:0]         norm
);

	qns_pkg::quat_t                     q_q;
	logic                               busy_q;
	logic [2:0]                         cnt_q;
	logic                               pv_q;
	logic [2*qns_pkg::COMP_W-1:0]       prod_q;
	logic [qns_pkg::NORM_W-1:0]         acc_q;
	logic                               done_q;
	qns_pkg::comp_t                     cur;
	logic signed [2*qns_pkg::COMP_W-1:0] sq;

	assign cur  = $signed(q_q[cnt_q[1:0]]);
	assign sq   = cur * cur;
	assign done = done_q;
	assign norm = acc_q;

	// The product of a step is registered and added in the next cycle; done rises after the last add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			pv_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				q_q    <= quat;
				busy_q <= 1'b1;
				cnt_q  <= '0;
				pv_q   <= 1'b0;
				acc_q  <= '0;
			end else if (busy_q) begin
				if (pv_q) begin
					acc_q <= acc_q + qns_pkg::NORM_W'(prod_q);
				end
				if (cnt_q != 3'(qns_pkg::NCOMP)) begin
					prod_q <= sq;
					pv_q   <= 1'b1;
					cnt_q  <= cnt_q + 3'd1;
				end else begin
					pv_q   <= 1'b0;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire
